// ===== rtl/bmma_pkg.sv =====
`timescale 1ns / 1ps

package bmma_pkg;

    // Opcodes of an input word
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_LOAD_C  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_BATCH_COUNT = 1'b1;

    localparam int CFG_DATA_W = 11;
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 64;
    localparam int RND_W      = 48;
    localparam int ACC_W      = 56;

    localparam logic signed [ELEM_W-1:0] SAT_HI = 32'sh7fff_ffff;
    localparam logic signed [ELEM_W-1:0] SAT_LO = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [2:0]               elem_row;
        logic [2:0]               elem_col;
        logic signed [ELEM_W-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               out_row;
        logic [2:0]               out_col;
        logic signed [ELEM_W-1:0] out_value;
        logic [9:0]               out_batch;
        logic                     out_last;
    } out_item_t;

    // Tag that travels with one product term through the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tag_t;

endpackage

// ===== rtl/bmma_ram.sv =====
`timescale 1ns / 1ps

module bmma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmma_mac.sv =====
`timescale 1ns / 1ps

module bmma_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bmma_pkg::tag_t                    tag_in,
    input  logic signed [bmma_pkg::ELEM_W-1:0] a_data,
    input  logic signed [bmma_pkg::ELEM_W-1:0] b_data,
    input  logic signed [bmma_pkg::ELEM_W-1:0] c_data,
    output logic                              done,
    output logic signed [bmma_pkg::ELEM_W-1:0] result
);

    import bmma_pkg::*;

    tag_t                      tag2_reg, tag3_reg, tag4_reg;
    logic signed [PROD_W-1:0]  p_reg, p_next;
    logic signed [RND_W-1:0]   r_reg, r_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ELEM_W-1:0]  c_hold_reg;

    always_comb begin
        p_next   = a_data * b_data;
        // round half up: floor((p + 2^15) / 2^16)
        r_next   = RND_W'((p_reg + 64'sd32768) >>> 16);
        acc_next = (tag3_reg.first ? ACC_W'(c_hold_reg) : acc_reg) + ACC_W'(r_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
        r_reg <= r_next;
        if (tag_in.vld && tag_in.first) begin
            c_hold_reg <= c_data;
        end
        if (tag3_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    assign done = tag4_reg.vld && tag4_reg.last;

    always_comb begin
        if (acc_reg > ACC_W'(SAT_HI)) begin
            result = SAT_HI;
        end else if (acc_reg < ACC_W'(SAT_LO)) begin
            result = SAT_LO;
        end else begin
            result = ELEM_W'(acc_reg);
        end
    end

endmodule

// ===== rtl/batched_matrix_multiply_accumulate_top.sv =====
`timescale 1ns / 1ps
// Batched square matrix multiply-accumulate, signed Q16.16.
// Input channel (s_valid/s_ready/s_data): each word either loads one element
// of A, B or C into its store (no result) or commands a compute.
// A compute forms C += A*B over the first n rows and columns (n from the
// matrix_size register), writes the new C back and sends n*n result words on
// the m_ channel in row-major order, out_last on the final one, each tagged
// with the batch index, which then advances and wraps at batch_count.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while idle;
// the block itself does not enforce it. A compute holds s_ready low until its
// last element completes. One multiply-accumulate pipeline (read, multiply,
// round, accumulate) takes one product per cycle once an element has started,
// fed by a single read port on each store, and each element drains the
// pipeline before the next starts.
// Receiver stall: the result register holds its word; the next element does
// not start until that word is taken, so nothing is lost.
// Reset (aresetn, synchronous, active low): sequencer idle, batch index zero,
// matrix_size 8, batch_count 1. Stores are not cleared: read before write is
// undefined.
module batched_matrix_multiply_accumulate_top #(
    parameter int MAX_DIM   = 8,
    parameter int MAX_BATCH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bmma_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bmma_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [bmma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import bmma_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int BCMP_W = 17;
    localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DIM_W-1:0]  n_m1_reg, n_m1_next;
    logic [BIDX_W-1:0] batch_reg, batch_next;
    logic [3:0]        cfg_size_reg;
    logic [10:0]       cfg_bcnt_reg;
    tag_t              tag1_reg, tag1_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              in_fire, ld_fire, comp_fire, out_free, issue_fire;
    logic              last_elem;
    logic [ADDR_W-1:0] ld_addr, a_raddr, b_raddr, c_raddr, c_waddr;
    logic              a_we, b_we, c_we;
    logic [ELEM_W-1:0] c_wdata, a_rdata, b_rdata, c_rdata;
    logic              mac_done;
    logic signed [ELEM_W-1:0] mac_res;
    logic [BCMP_W-1:0] bidx_inc, bcnt_eff;

    // Input side: loads go straight to the stores while idle.
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign comp_fire = in_fire && (s_data.opcode == OP_COMPUTE);
    assign ld_fire   = in_fire && (s_data.opcode != OP_COMPUTE)
                       && (int'(s_data.elem_row) < MAX_DIM)
                       && (int'(s_data.elem_col) < MAX_DIM);
    assign ld_addr   = ADDR_W'(s_data.elem_row) * DIM_A + ADDR_W'(s_data.elem_col);

    assign a_we    = ld_fire && (s_data.opcode == OP_LOAD_A);
    assign b_we    = ld_fire && (s_data.opcode == OP_LOAD_B);
    assign c_we    = (ld_fire && (s_data.opcode == OP_LOAD_C)) || mac_done;
    assign c_waddr = mac_done ? c_raddr : ld_addr;
    assign c_wdata = mac_done ? mac_res : s_data.elem_value;

    assign a_raddr = ADDR_W'(i_reg) * DIM_A + ADDR_W'(k_reg);
    assign b_raddr = ADDR_W'(k_reg) * DIM_A + ADDR_W'(j_reg);
    assign c_raddr = ADDR_W'(i_reg) * DIM_A + ADDR_W'(j_reg);

    // Start an element only once the result register will be free for it.
    assign out_free   = !m_valid_reg || m_ready;
    assign issue_fire = (state_reg == ST_ISSUE) && ((k_reg != '0) || out_free);
    assign last_elem  = (i_reg == n_m1_reg) && (j_reg == n_m1_reg);

    assign tag1_next.vld   = issue_fire;
    assign tag1_next.first = (k_reg == '0);
    assign tag1_next.last  = (k_reg == n_m1_reg);

    // Batch index wrap, with batch_count clamped to 1..MAX_BATCH
    always_comb begin
        bidx_inc = BCMP_W'(batch_reg) + BCMP_W'(1);
        if (cfg_bcnt_reg == '0) begin
            bcnt_eff = BCMP_W'(1);
        end else if (int'(cfg_bcnt_reg) > MAX_BATCH) begin
            bcnt_eff = BCMP_W'(MAX_BATCH);
        end else begin
            bcnt_eff = BCMP_W'(cfg_bcnt_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_m1_next  = n_m1_reg;
        batch_next = batch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (comp_fire) begin
                    // Clamp matrix_size to 1..MAX_DIM, hold n-1
                    if (cfg_size_reg == '0) begin
                        n_m1_next = '0;
                    end else if (int'(cfg_size_reg) > MAX_DIM) begin
                        n_m1_next = DIM_W'(MAX_DIM - 1);
                    end else begin
                        n_m1_next = DIM_W'(cfg_size_reg - 4'd1);
                    end
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue_fire) begin
                    if (k_reg == n_m1_reg) begin
                        state_next = ST_WAIT;
                    end else begin
                        k_next = k_reg + DIM_W'(1);
                    end
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    k_next = '0;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                        batch_next = (bidx_inc >= bcnt_eff) ? '0 : BIDX_W'(bidx_inc);
                    end else begin
                        state_next = ST_ISSUE;
                        if (j_reg == n_m1_reg) begin
                            j_next = '0;
                            i_next = i_reg + DIM_W'(1);
                        end else begin
                            j_next = j_reg + DIM_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            n_m1_reg     <= '0;
            batch_reg    <= '0;
            cfg_size_reg <= 4'd8;
            cfg_bcnt_reg <= 11'd1;
            tag1_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            n_m1_reg  <= n_m1_next;
            batch_reg <= batch_next;
            tag1_reg  <= tag1_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MATRIX_SIZE: cfg_size_reg <= cfg_wdata[3:0];
                    CFG_BATCH_COUNT: cfg_bcnt_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (mac_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register: hold the word until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (mac_done) begin
            m_data_reg.out_row   <= 3'(i_reg);
            m_data_reg.out_col   <= 3'(j_reg);
            m_data_reg.out_value <= mac_res;
            m_data_reg.out_batch <= 10'(batch_reg);
            m_data_reg.out_last  <= last_elem;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    bmma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (ld_addr),
        .wdata (s_data.elem_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bmma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (ld_addr),
        .wdata (s_data.elem_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    bmma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_c_store (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    bmma_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (tag1_reg),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .c_data  (c_rdata),
        .done    (mac_done),
        .result  (mac_res)
    );

`ifndef NO_ASSERTIONS
    // The store read pipeline is empty whenever new words are taken.
    a_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !tag1_reg.vld)
        else $error("product term in flight while input is open");

    // An element only completes into an empty result register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> !m_valid_reg)
        else $error("result register overwritten");

    // Completion is only seen while waiting for it.
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("element completed outside wait state");
`endif

endmodule
